// ===== rtl/oriented_rect_overlap_test_top_macros.svh =====
// Assertion macros used by the checker of this block.
`ifndef ORIENTED_RECT_OVERLAP_TEST_TOP_MACROS_SVH
`define ORIENTED_RECT_OVERLAP_TEST_TOP_MACROS_SVH

// Implication checked from the same edge, off during reset.
`define ORR_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked from the next edge, live during reset too.
`define ORR_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/orr_pkg.sv =====
package orr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 12;
  // Start cycle to result strobe.
  localparam int LATENCY = 7;
  // Width of one Q14 sine or cosine magnitude (0 to 16384).
  localparam int TRIG_W = 15;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Sign flags of one lane: A from its own edge, B from the other rectangle's edges.
  typedef struct packed {
    logic [3:0] a_neg;
    logic [3:0] a_zero;
    logic [3:0] b_neg;
    logic [3:0] b_zero;
  } lane_sgn_t;

  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned q30_sub(input longint unsigned u);
    return (u > ONE_Q30) ? 64'd0 : ONE_Q30 - u;
  endfunction

  // Q14 {cos, sin} of a first-quadrant angle, Taylor series in Horner form.
  function automatic logic [2*TRIG_W-1:0] trig_entry(input int unsigned idx,
                                                     input int unsigned abits);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned c;
    r  = (longint'(idx) << (16 - abits)) & 64'h3FFF;
    x  = (r * HALF_PI_Q30) >> 14;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = q30_sub(q30_mul(x2, t) / 110);
    t  = q30_sub(q30_mul(x2, t) / 72);
    t  = q30_sub(q30_mul(x2, t) / 42);
    t  = q30_sub(q30_mul(x2, t) / 20);
    t  = q30_sub(q30_mul(x2, t) / 6);
    s  = (((x * t) >> 30) + 64'd32768) >> 16;
    t  = ONE_Q30;
    t  = q30_sub(q30_mul(x2, t) / 132);
    t  = q30_sub(q30_mul(x2, t) / 90);
    t  = q30_sub(q30_mul(x2, t) / 56);
    t  = q30_sub(q30_mul(x2, t) / 30);
    t  = q30_sub(q30_mul(x2, t) / 12);
    t  = q30_sub(q30_mul(x2, t) / 2);
    c  = (t + 64'd32768) >> 16;
    return {c[TRIG_W-1:0], s[TRIG_W-1:0]};
  endfunction

endpackage

// ===== rtl/orr_corner.sv =====
module orr_corner #(
  parameter int COORD_BITS = orr_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = orr_pkg::ANGLE_BITS_DEF,
  localparam int PW = COORD_BITS + 18
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic        [COORD_BITS-1:0] width,
  input  logic        [COORD_BITS-1:0] height,
  input  logic        [ANGLE_BITS-1:0] angle,
  output logic signed [PW-1:0]         corner_x [4],
  output logic signed [PW-1:0]         corner_y [4]
);
  import orr_pkg::*;

  localparam int IDX_W  = ANGLE_BITS - 2;
  localparam int TDEPTH = 1 << IDX_W;
  localparam int MW     = COORD_BITS + 17;
  // Corners 1,2 take -w, corners 2,3 take -h.
  localparam logic [3:0] NEG_W = 4'b0110;
  localparam logic [3:0] NEG_H = 4'b1100;

  logic [2*TRIG_W-1:0] trig_rom [TDEPTH];

  for (genvar g = 0; g < TDEPTH; g++) begin : g_rom
    assign trig_rom[g] = trig_entry(g, ANGLE_BITS);
  end

  // table read
  logic [2*TRIG_W-1:0]         sc_r;
  logic [1:0]                  quad_r;
  logic signed [COORD_BITS-1:0] cx_a_r, cy_a_r;
  logic [COORD_BITS-1:0]        w_a_r, h_a_r;

  always_ff @(posedge clk) begin
    sc_r   <= trig_rom[angle[IDX_W-1:0]];
    quad_r <= angle[ANGLE_BITS-1 -: 2];
    cx_a_r <= center_x;
    cy_a_r <= center_y;
    w_a_r  <= width;
    h_a_r  <= height;
  end

  // quadrant fold and scaling
  logic signed [TRIG_W:0] c_s, s_s, co, si;
  logic signed [COORD_BITS:0] w_s, h_s;
  logic signed [MW-1:0] wc_r, hs_r, ws_r, hc_r;
  logic signed [COORD_BITS-1:0] cx_b_r, cy_b_r;

  assign c_s = signed'({1'b0, sc_r[2*TRIG_W-1:TRIG_W]});
  assign s_s = signed'({1'b0, sc_r[TRIG_W-1:0]});
  assign w_s = signed'({1'b0, w_a_r});
  assign h_s = signed'({1'b0, h_a_r});

  always_comb begin
    unique case (quad_r)
      QUAD_I: begin
        co = c_s;
        si = s_s;
      end
      QUAD_II: begin
        co = -s_s;
        si = c_s;
      end
      QUAD_III: begin
        co = -c_s;
        si = -s_s;
      end
      default: begin
        co = s_s;
        si = -c_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    wc_r   <= w_s * co;
    hs_r   <= h_s * si;
    ws_r   <= w_s * si;
    hc_r   <= h_s * co;
    cx_b_r <= cx_a_r;
    cy_b_r <= cy_a_r;
  end

  // translate to the center
  logic signed [PW-1:0] base_x, base_y;
  logic signed [PW-1:0] px_nxt [4];
  logic signed [PW-1:0] py_nxt [4];
  logic signed [PW-1:0] px_r [4];
  logic signed [PW-1:0] py_r [4];

  assign base_x = PW'(signed'({cx_b_r, 15'd0}));
  assign base_y = PW'(signed'({cy_b_r, 15'd0}));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px_nxt[k] = base_x + (NEG_W[k] ? -PW'(wc_r) : PW'(wc_r))
                         - (NEG_H[k] ? -PW'(hs_r) : PW'(hs_r));
      py_nxt[k] = base_y + (NEG_W[k] ? -PW'(ws_r) : PW'(ws_r))
                         + (NEG_H[k] ? -PW'(hc_r) : PW'(hc_r));
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
  end

  assign corner_x = px_r;
  assign corner_y = py_r;

endmodule

// ===== rtl/orr_lane.sv =====
module orr_lane #(
  parameter int COORD_BITS = orr_pkg::COORD_BITS_DEF,
  localparam int PW = COORD_BITS + 18
) (
  input  logic                 clk,
  input  logic signed [PW-1:0] p_x,
  input  logic signed [PW-1:0] p_y,
  input  logic signed [PW-1:0] pn_x,
  input  logic signed [PW-1:0] pn_y,
  input  logic signed [PW-1:0] q_x [4],
  input  logic signed [PW-1:0] q_y [4],
  output orr_pkg::lane_sgn_t   sgn
);
  import orr_pkg::*;

  localparam int DW = PW + 1;
  localparam int LO = DW / 2;
  localparam int HW = 2 * DW - LO;
  localparam int LW = DW + LO + 1;
  localparam int CW = 2 * DW + 2;

  // edge and offset vectors
  logic signed [DW-1:0] v1x_r, v1y_r;
  logic signed [DW-1:0] ex_r [4];
  logic signed [DW-1:0] ey_r [4];
  logic signed [DW-1:0] v2x_r [4];
  logic signed [DW-1:0] v2y_r [4];

  always_ff @(posedge clk) begin
    v1x_r <= DW'(pn_x) - DW'(p_x);
    v1y_r <= DW'(pn_y) - DW'(p_y);
    for (int j = 0; j < 4; j++) begin
      ex_r[j]  <= DW'(q_x[j]) - DW'(p_x);
      ey_r[j]  <= DW'(q_y[j]) - DW'(p_y);
      v2x_r[j] <= DW'(q_x[(j + 1) % 4]) - DW'(q_x[j]);
      v2y_r[j] <= DW'(q_y[(j + 1) % 4]) - DW'(q_y[j]);
    end
  end

  // split offsets into high and low halves for the partial products
  logic signed [DW-LO-1:0] exh [4];
  logic signed [DW-LO-1:0] eyh [4];
  logic signed [LO:0]      exl [4];
  logic signed [LO:0]      eyl [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      exh[j] = signed'(ex_r[j][DW-1:LO]);
      eyh[j] = signed'(ey_r[j][DW-1:LO]);
      exl[j] = signed'({1'b0, ex_r[j][LO-1:0]});
      eyl[j] = signed'({1'b0, ey_r[j][LO-1:0]});
    end
  end

  logic signed [HW-1:0] ah1_r [4];
  logic signed [HW-1:0] ah2_r [4];
  logic signed [LW-1:0] al1_r [4];
  logic signed [LW-1:0] al2_r [4];
  logic signed [HW-1:0] bh1_r [4];
  logic signed [HW-1:0] bh2_r [4];
  logic signed [LW-1:0] bl1_r [4];
  logic signed [LW-1:0] bl2_r [4];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      ah1_r[j] <= v1x_r * eyh[j];
      ah2_r[j] <= v1y_r * exh[j];
      al1_r[j] <= v1x_r * eyl[j];
      al2_r[j] <= v1y_r * exl[j];
      bh1_r[j] <= v2x_r[j] * eyh[j];
      bh2_r[j] <= v2y_r[j] * exh[j];
      bl1_r[j] <= v2x_r[j] * eyl[j];
      bl2_r[j] <= v2y_r[j] * exl[j];
    end
  end

  // {negative, zero} of the recombined cross product
  function automatic logic [1:0] csign(input logic signed [HW-1:0] h1,
                                       input logic signed [HW-1:0] h2,
                                       input logic signed [LW-1:0] l1,
                                       input logic signed [LW-1:0] l2);
    logic signed [CW-1:0] v;
    v = ((CW'(h1) - CW'(h2)) <<< LO) + (CW'(l1) - CW'(l2));
    return {v[CW-1], v == '0};
  endfunction

  lane_sgn_t sgn_nxt, sgn_r;
  logic [1:0] sa [4];
  logic [1:0] sb [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sa[j] = csign(ah1_r[j], ah2_r[j], al1_r[j], al2_r[j]);
      sb[j] = csign(bh1_r[j], bh2_r[j], bl1_r[j], bl2_r[j]);
      sgn_nxt.a_neg[j]  = sa[j][1];
      sgn_nxt.a_zero[j] = sa[j][0];
      // B uses the negated offset: flip the sign
      sgn_nxt.b_neg[j]  = !sb[j][1] && !sb[j][0];
      sgn_nxt.b_zero[j] = sb[j][0];
    end
  end

  always_ff @(posedge clk) begin
    sgn_r <= sgn_nxt;
  end

  assign sgn = sgn_r;

endmodule

// ===== rtl/orr_merge.sv =====
module orr_merge #(
  parameter int COORD_BITS = orr_pkg::COORD_BITS_DEF,
  localparam int PW = COORD_BITS + 18
) (
  input  logic                 clk,
  input  logic signed [PW-1:0] p_x [4],
  input  logic signed [PW-1:0] p_y [4],
  input  logic signed [PW-1:0] q_x [4],
  input  logic signed [PW-1:0] q_y [4],
  input  orr_pkg::lane_sgn_t   sgn [4],
  output logic                 hit
);
  import orr_pkg::*;

  // bounding boxes
  logic signed [PW-1:0] pxl_nxt, pxh_nxt, pyl_nxt, pyh_nxt;
  logic signed [PW-1:0] qxl_nxt, qxh_nxt, qyl_nxt, qyh_nxt;
  logic signed [PW-1:0] pxl_r, pxh_r, pyl_r, pyh_r;
  logic signed [PW-1:0] qxl_r, qxh_r, qyl_r, qyh_r;
  logic signed [PW-1:0] pxd_r [4];
  logic signed [PW-1:0] pyd_r [4];
  logic signed [PW-1:0] qxd_r [4];
  logic signed [PW-1:0] qyd_r [4];

  always_comb begin
    pxl_nxt = p_x[0];
    pxh_nxt = p_x[0];
    pyl_nxt = p_y[0];
    pyh_nxt = p_y[0];
    qxl_nxt = q_x[0];
    qxh_nxt = q_x[0];
    qyl_nxt = q_y[0];
    qyh_nxt = q_y[0];
    for (int k = 1; k < 4; k++) begin
      if (p_x[k] < pxl_nxt) pxl_nxt = p_x[k];
      if (p_x[k] > pxh_nxt) pxh_nxt = p_x[k];
      if (p_y[k] < pyl_nxt) pyl_nxt = p_y[k];
      if (p_y[k] > pyh_nxt) pyh_nxt = p_y[k];
      if (q_x[k] < qxl_nxt) qxl_nxt = q_x[k];
      if (q_x[k] > qxh_nxt) qxh_nxt = q_x[k];
      if (q_y[k] < qyl_nxt) qyl_nxt = q_y[k];
      if (q_y[k] > qyh_nxt) qyh_nxt = q_y[k];
    end
  end

  always_ff @(posedge clk) begin
    pxl_r <= pxl_nxt;
    pxh_r <= pxh_nxt;
    pyl_r <= pyl_nxt;
    pyh_r <= pyh_nxt;
    qxl_r <= qxl_nxt;
    qxh_r <= qxh_nxt;
    qyl_r <= qyl_nxt;
    qyh_r <= qyh_nxt;
    pxd_r <= p_x;
    pyd_r <= p_y;
    qxd_r <= q_x;
    qyd_r <= q_y;
  end

  // containment, inclusive bounds
  logic q_in_p_nxt, p_in_q_nxt;
  logic cont_a_r, cont_b_r;

  always_comb begin
    q_in_p_nxt = 1'b1;
    p_in_q_nxt = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (qxd_r[k] < pxl_r || qxd_r[k] > pxh_r || qyd_r[k] < pyl_r || qyd_r[k] > pyh_r)
        q_in_p_nxt = 1'b0;
      if (pxd_r[k] < qxl_r || pxd_r[k] > qxh_r || pyd_r[k] < qyl_r || pyd_r[k] > qyh_r)
        p_in_q_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cont_a_r <= q_in_p_nxt || p_in_q_nxt;
    cont_b_r <= cont_a_r;
  end

  // edge pair i of first against j of second
  logic cross_any;
  logic side_a, side_b;

  always_comb begin
    cross_any = 1'b0;
    side_a    = 1'b0;
    side_b    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        side_a = sgn[i].a_zero[j] || sgn[i].a_zero[(j + 1) % 4] ||
                 (sgn[i].a_neg[j] ^ sgn[i].a_neg[(j + 1) % 4]);
        side_b = sgn[i].b_zero[j] || sgn[(i + 1) % 4].b_zero[j] ||
                 (sgn[i].b_neg[j] ^ sgn[(i + 1) % 4].b_neg[j]);
        if (side_a && side_b) cross_any = 1'b1;
      end
    end
  end

  logic hit_r;

  always_ff @(posedge clk) begin
    hit_r <= cross_any || cont_b_r;
  end

  assign hit = hit_r;

endmodule

// ===== rtl/oriented_rect_overlap_test_top.sv =====
// Oriented rectangle overlap test, fully pipelined.
// Throughput: one rectangle pair per cycle; busy is always low. The 7 stages are table read,
// scale, translate, edge differences, partial products, sign recombine and lane merge.
// Reset (rst_n low, synchronous) clears the valid pipeline; words in flight drop.
module oriented_rect_overlap_test_top #(
  parameter int COORD_BITS = orr_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = orr_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_first_center_x,
  input  logic signed [COORD_BITS-1:0] in_first_center_y,
  input  logic        [COORD_BITS-1:0] in_first_width,
  input  logic        [COORD_BITS-1:0] in_first_height,
  input  logic        [ANGLE_BITS-1:0] in_first_angle,
  input  logic signed [COORD_BITS-1:0] in_second_center_x,
  input  logic signed [COORD_BITS-1:0] in_second_center_y,
  input  logic        [COORD_BITS-1:0] in_second_width,
  input  logic        [COORD_BITS-1:0] in_second_height,
  input  logic        [ANGLE_BITS-1:0] in_second_angle,
  output logic                         out_valid,
  output logic                         out_hit
);
  import orr_pkg::*;

  localparam int PW = COORD_BITS + 18;

  // The pipeline never stalls: accept a word every cycle.
  assign busy = 1'b0;

  // Valid flag travels beside the data; payload stages carry no reset.
  logic [LATENCY-1:0] vld_r, vld_nxt;

  assign vld_nxt = {vld_r[LATENCY-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[LATENCY-1];

  // Stages 1-3: corners of each rectangle, in units of 2^-15.
  logic signed [PW-1:0] p_x [4];
  logic signed [PW-1:0] p_y [4];
  logic signed [PW-1:0] q_x [4];
  logic signed [PW-1:0] q_y [4];

  orr_corner #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_corner_first (
    .clk      (clk),
    .center_x (in_first_center_x),
    .center_y (in_first_center_y),
    .width    (in_first_width),
    .height   (in_first_height),
    .angle    (in_first_angle),
    .corner_x (p_x),
    .corner_y (p_y)
  );

  orr_corner #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_corner_second (
    .clk      (clk),
    .center_x (in_second_center_x),
    .center_y (in_second_center_y),
    .width    (in_second_width),
    .height   (in_second_height),
    .angle    (in_second_angle),
    .corner_x (q_x),
    .corner_y (q_y)
  );

  // Stages 4-6: one lane per edge of the first rectangle. Each lane finds
  // the side of every second-rectangle corner against its edge, and the
  // side of its start corner against every second-rectangle edge.
  lane_sgn_t sgn [4];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    orr_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk  (clk),
      .p_x  (p_x[i]),
      .p_y  (p_y[i]),
      .pn_x (p_x[(i + 1) % 4]),
      .pn_y (p_y[(i + 1) % 4]),
      .q_x  (q_x),
      .q_y  (q_y),
      .sgn  (sgn[i])
    );
  end

  // Stages 4-7: box containment beside the lanes, then combine the lanes
  // into one hit per pair.
  orr_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk (clk),
    .p_x (p_x),
    .p_y (p_y),
    .q_x (q_x),
    .q_y (q_y),
    .sgn (sgn),
    .hit (out_hit)
  );

endmodule

// ===== rtl/orr_checker.sv =====
`include "oriented_rect_overlap_test_top_macros.svh"

module orr_checker #(
  parameter int COORD_BITS = orr_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = orr_pkg::ANGLE_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic signed [COORD_BITS-1:0] in_first_center_x,
  input logic signed [COORD_BITS-1:0] in_first_center_y,
  input logic        [COORD_BITS-1:0] in_first_width,
  input logic        [COORD_BITS-1:0] in_first_height,
  input logic        [ANGLE_BITS-1:0] in_first_angle,
  input logic signed [COORD_BITS-1:0] in_second_center_x,
  input logic signed [COORD_BITS-1:0] in_second_center_y,
  input logic        [COORD_BITS-1:0] in_second_width,
  input logic        [COORD_BITS-1:0] in_second_height,
  input logic        [ANGLE_BITS-1:0] in_second_angle,
  input logic                         out_valid,
  input logic                         out_hit
);
  import orr_pkg::*;

  // A rectangle always touches an exact copy of itself.
  logic same_pair;

  assign same_pair = start && !busy &&
                     in_first_center_x == in_second_center_x &&
                     in_first_center_y == in_second_center_y &&
                     in_first_width == in_second_width &&
                     in_first_height == in_second_height &&
                     in_first_angle == in_second_angle;

  `ORR_CHECK(a_word_out, start && !busy, ##LATENCY out_valid, "accepted word lost")
  `ORR_CHECK(a_no_extra, out_valid, $past(start && !busy, LATENCY), "result without a word")
  `ORR_CHECK(a_self_hit, out_valid && $past(same_pair, LATENCY), out_hit, "identical pair missed")
  `ORR_CHECK_NEXT(a_rst_quiet, !rst_n, !out_valid, "result right after reset")

endmodule

bind oriented_rect_overlap_test_top orr_checker #(
  .COORD_BITS (COORD_BITS),
  .ANGLE_BITS (ANGLE_BITS)
) u_orr_checker (.*);
